/* hdl/dpbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpbc_pkg
// Shared types, constants and codes of the day-phase brightness clock.
// ----------------------------------------------------------------------------
package dpbc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned HOUR_W     = 5;
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned SOD_W      = 17;
    localparam int unsigned DIV_DVD_W  = 64;
    localparam int unsigned DIV_DVS_W  = 27;
    localparam int unsigned DIV_CNT_W  = 7;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DAWN_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUSK_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_LEVEL   = 3'd5;

    // Phase codes
    localparam logic [1:0] PH_NIGHT = 2'd0;
    localparam logic [1:0] PH_DAWN  = 2'd1;
    localparam logic [1:0] PH_DAY   = 2'd2;
    localparam logic [1:0] PH_DUSK  = 2'd3;

    // Request kinds on the input tuser bit
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_ANCHOR = 1'b1;

    localparam logic [SOD_W-1:0] SEC_PER_HOUR = 17'd3600;

    // Second-of-day reduction: 86,400,000 = 1024 * 84375 and 1000 = 8 * 125
    localparam logic [16:0] DAY_MS_K   = 17'd84375;
    localparam logic [13:0] FOLD_C1    = 14'd9019;    // 2^18 mod 84375
    localparam logic [12:0] FOLD_C2    = 13'd4861;    // 2^36 mod 84375
    localparam logic [15:0] DAY_MS_RCP = 16'd50903;   // floor(2^32 / 84375)
    localparam logic [6:0]  SEC_K      = 7'd125;
    localparam logic [17:0] SEC_RCP    = 18'd134217;  // floor(2^24 / 125)

    typedef struct packed {
        logic [HOUR_W-1:0]  dawn_start;
        logic [HOUR_W-1:0]  day_start;
        logic [HOUR_W-1:0]  dusk_start;
        logic [HOUR_W-1:0]  night_start;
        logic [LEVEL_W-1:0] night_level;
        logic [LEVEL_W-1:0] day_level;
    } cfg_t;

    typedef struct packed {
        logic        known;
        logic [63:0] wall;
    } queue_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;   // MSB-aligned
        logic [DIV_DVS_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quot;
    } div_rsp_t;

    function automatic logic [SOD_W-1:0] hour_to_sec(input logic [HOUR_W-1:0] h);
        return SOD_W'(h) * SEC_PER_HOUR;
    endfunction

endpackage
`default_nettype wire

/* hdl/day_phase_brightness_clock.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: a set-anchor request gives no result. A tick passes the front's pending register,
//   the queue and the back's states (a 34-step blend divide inside a dawn or dusk ramp)
//   before m_tvalid rises from the output register.
// Flow: the back part works on one wall time at a time, but the front takes new ticks
//   until the queue fills; a stalled m_tready holds the back, then s_tready.
// Reset: synchronous active-low; clocks, anchor, queue, configuration and control state reset.
// ----------------------------------------------------------------------------
// day_phase_brightness_clock
// Millisecond monotonic clock with wall anchor, giving day phase and brightness.
// ----------------------------------------------------------------------------
module day_phase_brightness_clock
    import dpbc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [95:0]           s_tdata,   // [31:0] delta_ms, [95:32] anchor_ms
    input  wire logic                  s_tuser,   // [0] req_type
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata    // [1:0] phase, [17:2] brightness,
                                                  // [18] quiet, [19] time_known
);

    cfg_t        cfg_reg, cfg_next;
    logic        q_push, q_full, q_pop, q_not_empty;
    queue_item_t q_push_item, q_head;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // Configuration registers; an index past the last register is dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DAWN_START:  cfg_next.dawn_start  = cfg_wdata[HOUR_W-1:0];
                REG_DAY_START:   cfg_next.day_start   = cfg_wdata[HOUR_W-1:0];
                REG_DUSK_START:  cfg_next.dusk_start  = cfg_wdata[HOUR_W-1:0];
                REG_NIGHT_START: cfg_next.night_start = cfg_wdata[HOUR_W-1:0];
                REG_NIGHT_LEVEL: cfg_next.night_level = cfg_wdata[LEVEL_W-1:0];
                REG_DAY_LEVEL:   cfg_next.day_level   = cfg_wdata[LEVEL_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dawn_start  <= 5'd6;
            cfg_reg.day_start   <= 5'd8;
            cfg_reg.dusk_start  <= 5'd18;
            cfg_reg.night_start <= 5'd22;
            cfg_reg.night_level <= 16'd6554;
            cfg_reg.day_level   <= 16'd32768;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: take requests, advance the monotonic clock, form the wall time.
    dpbc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_delta  (s_tdata[31:0]),
        .in_anchor (s_tdata[95:32]),
        .push      (q_push),
        .push_item (q_push_item),
        .q_full    (q_full)
    );

    // Queue: decouple request intake from the slow divide chain.
    dpbc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Back: second of the day, phase pick, ramp blend, output register.
    dpbc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

    // Serial divider for the ramp blend.
    dpbc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Quiet only at night.
    a_quiet_night: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tdata[1:0] == PH_NIGHT)
        else $error("quiet outside night");

    // Quiet only once time is known.
    a_quiet_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tdata[19])
        else $error("quiet without anchor");

    // Without an anchor the result is plain day.
    a_unknown_day: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[19] |-> m_tdata[1:0] == PH_DAY)
        else $error("unanchored result not day");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("queue overflow");

endmodule
`default_nettype wire

/* hdl/dpbc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpbc_div
// Restoring divider, one quotient bit per cycle, MSB-aligned dividend.
// ----------------------------------------------------------------------------
module dpbc_div
    import dpbc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_DVD_W-1:0] quot_reg, quot_next;
    logic [DIV_DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_DVS_W:0] trial;
    logic               ge;

    assign trial = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = req.steps;
            quot_next = '0;
            rem_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract when it fits
            rem_next  = ge ? DIV_DVS_W'(trial - {1'b0, dvs_reg}) : trial[DIV_DVS_W-1:0];
            quot_next = {quot_reg[DIV_DVD_W-2:0], ge};
            dvd_next  = {dvd_reg[DIV_DVD_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
`default_nettype wire

/* hdl/dpbc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpbc_fifo
// Two-entry queue of wall times between the front and back parts.
// ----------------------------------------------------------------------------
module dpbc_fifo
    import dpbc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire queue_item_t push_item,
    output logic             full,
    input  wire logic        pop,
    output logic             not_empty,
    output queue_item_t      head
);

    queue_item_t mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push, do_pop;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/dpbc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpbc_front
// Accepts requests, keeps the monotonic clock and anchor, queues wall times.
// ----------------------------------------------------------------------------
module dpbc_front
    import dpbc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        in_kind,
    input  wire logic [31:0] in_delta,
    input  wire logic [63:0] in_anchor,
    output logic             push,
    output queue_item_t      push_item,
    input  wire logic        q_full
);

    logic [63:0] mono_reg, mono_next;
    // wall anchor minus monotonic time at the anchor, modulo 2^64
    logic [63:0] offset_reg, offset_next;
    logic        anchored_reg, anchored_next;
    logic        pend_reg, pend_next;
    logic        take;

    assign in_ready = !pend_reg;
    assign take     = in_valid && in_ready;
    assign push     = pend_reg && !q_full;

    assign push_item.known = anchored_reg;
    assign push_item.wall  = offset_reg + mono_reg;

    always_comb begin
        mono_next     = mono_reg;
        offset_next   = offset_reg;
        anchored_next = anchored_reg;
        pend_next     = pend_reg;
        if (push) begin
            pend_next = 1'b0;
        end
        if (take) begin
            if (in_kind == REQ_ANCHOR) begin
                offset_next   = in_anchor - mono_reg;
                anchored_next = 1'b1;
            end else begin
                mono_next = mono_reg + 64'(in_delta);
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mono_reg     <= '0;
            offset_reg   <= '0;
            anchored_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            mono_reg     <= mono_next;
            offset_reg   <= offset_next;
            anchored_reg <= anchored_next;
            pend_reg     <= pend_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/dpbc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpbc_back
// Turns a queued wall time into phase and brightness; a serial divider blends.
// ----------------------------------------------------------------------------
module dpbc_back
    import dpbc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        q_not_empty,
    input  wire queue_item_t q_head,
    output logic             q_pop,
    output div_req_t         div_req,
    input  wire div_rsp_t    div_rsp,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [23:0]      out_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FOLD  = 4'd1;
    localparam logic [3:0] ST_QEST  = 4'd2;
    localparam logic [3:0] ST_REM   = 4'd3;
    localparam logic [3:0] ST_FIX   = 4'd4;
    localparam logic [3:0] ST_SEC   = 4'd5;
    localparam logic [3:0] ST_SFIX  = 4'd6;
    localparam logic [3:0] ST_CLASS = 4'd7;
    localparam logic [3:0] ST_RAMP  = 4'd8;
    localparam logic [3:0] ST_MUL0  = 4'd9;
    localparam logic [3:0] ST_MUL1  = 4'd10;
    localparam logic [3:0] ST_SUM   = 4'd11;
    localparam logic [3:0] ST_RDIV  = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    logic [3:0]         state_reg, state_next;
    logic [63:0]        wall_reg, wall_next;
    logic [31:0]        z_reg, z_next;
    logic [15:0]        qe_reg, qe_next;
    logic [17:0]        r_reg, r_next;
    logic [23:0]        v_reg, v_next;
    logic [17:0]        sq_reg, sq_next;
    logic [SOD_W-1:0]   sod_reg, sod_next;
    logic [SOD_W-1:0]   num_reg, num_next;
    logic [SOD_W-1:0]   den_reg, den_next;
    logic [LEVEL_W-1:0] from_reg, from_next;
    logic [LEVEL_W-1:0] to_reg, to_next;
    logic [32:0]        prod0_reg, prod0_next;
    logic [32:0]        prod1_reg, prod1_next;
    logic [1:0]         phase_reg, phase_next;
    logic [LEVEL_W-1:0] bright_reg, bright_next;
    logic               quiet_reg, quiet_next;
    logic               known_reg, known_next;
    logic               ovalid_reg, ovalid_next;
    logic [23:0]        odata_reg, odata_next;

    logic [SOD_W-1:0] dawn_sec, day_sec, dusk_sec, night_sec;
    logic [SOD_W-1:0] ramp_a, ramp_b;
    logic [33:0]      blend_sum;
    logic [31:0]      fold_sum;
    logic [47:0]      qe_prod;
    logic [32:0]      qe_back;
    logic [32:0]      r_diff;
    logic [17:0]      r_fix;
    logic [41:0]      sq_prod;
    logic [24:0]      sq_back;
    logic [24:0]      s_rem;

    assign dawn_sec  = hour_to_sec(cfg.dawn_start);
    assign day_sec   = hour_to_sec(cfg.day_start);
    assign dusk_sec  = hour_to_sec(cfg.dusk_start);
    assign night_sec = hour_to_sec(cfg.night_start);
    assign ramp_a    = (phase_reg == PH_DAWN) ? dawn_sec : dusk_sec;
    assign ramp_b    = (phase_reg == PH_DAWN) ? day_sec : night_sec;
    assign blend_sum = 34'(prod0_reg) + 34'(prod1_reg);

    // wall >> 10 folded in 18-bit chunks; congruent to it modulo 84375
    assign fold_sum = 32'(wall_reg[27:10])
                    + 32'(wall_reg[45:28]) * 32'(FOLD_C1)
                    + 32'(wall_reg[63:46]) * 32'(FOLD_C2);
    // reciprocal estimates are low by at most one; one subtract corrects them
    assign qe_prod  = 48'(z_reg) * 48'(DAY_MS_RCP);
    assign qe_back  = 33'(qe_reg) * 33'(DAY_MS_K);
    assign r_diff   = 33'(z_reg) - qe_back;
    assign r_fix    = (r_reg >= 18'(DAY_MS_K)) ? r_reg - 18'(DAY_MS_K) : r_reg;
    assign sq_prod  = 42'(v_reg) * 42'(SEC_RCP);
    assign sq_back  = 25'(sq_reg) * 25'(SEC_K);
    assign s_rem    = 25'(v_reg) - sq_back;

    always_comb begin
        state_next  = state_reg;
        wall_next   = wall_reg;
        z_next      = z_reg;
        qe_next     = qe_reg;
        r_next      = r_reg;
        v_next      = v_reg;
        sq_next     = sq_reg;
        sod_next    = sod_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        from_next   = from_reg;
        to_next     = to_reg;
        prod0_next  = prod0_reg;
        prod1_next  = prod1_reg;
        phase_next  = phase_reg;
        bright_next = bright_reg;
        quiet_next  = quiet_reg;
        known_next  = known_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        q_pop       = 1'b0;
        div_req     = '0;

        if (out_valid && out_ready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop       = 1'b1;
                    known_next  = q_head.known;
                    quiet_next  = 1'b0;
                    phase_next  = PH_DAY;
                    bright_next = cfg.day_level;
                    if (q_head.known) begin
                        wall_next  = q_head.wall;
                        state_next = ST_FOLD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FOLD: begin
                z_next     = fold_sum;
                state_next = ST_QEST;
            end
            ST_QEST: begin
                qe_next    = qe_prod[47:32];
                state_next = ST_REM;
            end
            ST_REM: begin
                r_next     = r_diff[17:0];
                state_next = ST_FIX;
            end
            ST_FIX: begin
                // ms of the day is r * 1024 + wall[9:0]; keep it divided by 8
                v_next     = {r_fix[16:0], wall_reg[9:3]};
                state_next = ST_SEC;
            end
            ST_SEC: begin
                sq_next    = sq_prod[41:24];
                state_next = ST_SFIX;
            end
            ST_SFIX: begin
                sod_next   = (s_rem >= 25'(SEC_K)) ? sq_reg[SOD_W-1:0] + SOD_W'(1)
                                                   : sq_reg[SOD_W-1:0];
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                // hour >= N is the same as second-of-day >= N * 3600
                if (sod_reg >= night_sec || sod_reg < dawn_sec) begin
                    phase_next  = PH_NIGHT;
                    bright_next = cfg.night_level;
                    quiet_next  = 1'b1;
                    state_next  = ST_DONE;
                end else if (sod_reg < day_sec) begin
                    phase_next = PH_DAWN;
                    from_next  = cfg.night_level;
                    to_next    = cfg.day_level;
                    state_next = ST_RAMP;
                end else if (sod_reg < dusk_sec) begin
                    phase_next  = PH_DAY;
                    bright_next = cfg.day_level;
                    state_next  = ST_DONE;
                end else begin
                    phase_next = PH_DUSK;
                    from_next  = cfg.day_level;
                    to_next    = cfg.night_level;
                    state_next = ST_RAMP;
                end
            end
            ST_RAMP: begin
                if (sod_reg <= ramp_a) begin
                    bright_next = from_reg;
                    state_next  = ST_DONE;
                end else if (sod_reg >= ramp_b) begin
                    bright_next = to_reg;
                    state_next  = ST_DONE;
                end else begin
                    num_next   = sod_reg - ramp_a;
                    den_next   = ramp_b - ramp_a;
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0: begin
                prod0_next = 33'(from_reg) * 33'(den_reg - num_reg);
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                prod1_next = 33'(to_reg) * 33'(num_reg);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                div_req.start    = 1'b1;
                div_req.dividend = {blend_sum, 30'd0};
                div_req.divisor  = DIV_DVS_W'(den_reg);
                div_req.steps    = DIV_CNT_W'(34);
                state_next       = ST_RDIV;
            end
            ST_RDIV: begin
                if (div_rsp.done) begin
                    bright_next = div_rsp.quot[LEVEL_W-1:0];
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!out_valid || out_ready) begin
                    ovalid_next = 1'b1;
                    odata_next  = {4'd0, known_reg, quiet_reg, bright_reg, phase_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
        wall_reg   <= wall_next;
        z_reg      <= z_next;
        qe_reg     <= qe_next;
        r_reg      <= r_next;
        v_reg      <= v_next;
        sq_reg     <= sq_next;
        sod_reg    <= sod_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        from_reg   <= from_next;
        to_reg     <= to_next;
        prod0_reg  <= prod0_next;
        prod1_reg  <= prod1_next;
        phase_reg  <= phase_next;
        bright_reg <= bright_next;
        quiet_reg  <= quiet_next;
        known_reg  <= known_next;
        odata_reg  <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule
`default_nettype wire
